FILE: sv/jsu_pkg.sv
// ============================================================================
// jsu_pkg
// Shared types and codes for the JSON string unescaper: the job word that
// passes from the front end to the output stage, status codes and error codes.
// ============================================================================
package jsu_pkg;

    // Default depth of the job queue between the front end and the output stage.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Result status codes.
    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;

    // Error codes.
    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_NOQUOTE = 3'd1;
    localparam logic [2:0] E_CTRL    = 3'd2;
    localparam logic [2:0] E_ESC     = 3'd3;
    localparam logic [2:0] E_HEX     = 3'd4;
    localparam logic [2:0] E_SURR    = 3'd5;
    localparam logic [2:0] E_END     = 3'd6;

    // One job: up to four result bytes, emitted from index 0 to last_idx.
    // Close and error jobs carry a single result with a zero byte.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic [1:0]      status;
        logic [2:0]      err;
    } t_job;

endpackage

FILE: sv/jsu_front.sv
// ============================================================================
// jsu_front
// Front end: runs the string/escape/hex state machine on each accepted word
// and produces at most one job (a UTF-8 sequence, a close or an error).
// ============================================================================
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_eoi,
    output logic          o_push,
    output jsu_pkg::t_job o_job
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_BODY  = 4'd1,
        PH_ESC   = 4'd2,
        PH_HEX1  = 4'd3,
        PH_LOWBS = 4'd4,
        PH_LOWU  = 4'd5,
        PH_HEX2  = 4'd6
    } t_phase;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // Returns {is_digit, value}.
    function automatic logic [4:0] f_hex(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, b[3:0]};
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return r;
    endfunction

    function automatic jsu_pkg::t_job f_utf8(input logic [20:0] cp);
        jsu_pkg::t_job j;
        j        = '0;
        j.status = jsu_pkg::ST_BYTE;
        j.err    = jsu_pkg::E_NONE;
        if (cp < 21'h80) begin
            j.bytes[0] = cp[7:0];
            j.last_idx = 2'd0;
        end else if (cp < 21'h800) begin
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
            j.last_idx = 2'd1;
        end else if (cp < SUPP_BASE) begin
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
            j.last_idx = 2'd2;
        end else begin
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
            j.last_idx = 2'd3;
        end
        return j;
    endfunction

    function automatic jsu_pkg::t_job f_single(input logic [7:0] b, input logic [1:0] st,
                                               input logic [2:0] err);
        jsu_pkg::t_job j;
        j          = '0;
        j.bytes[0] = b;
        j.last_idx = 2'd0;
        j.status   = st;
        j.err      = err;
        return j;
    endfunction

    t_phase      r_phase, n_phase;
    logic [15:0] r_code_unit, n_code_unit;
    logic [1:0]  r_hex_seen, n_hex_seen;
    logic [9:0]  r_high_half, n_high_half;

    logic [4:0]  hex;
    logic [15:0] unit;
    logic [20:0] cp_pair;
    logic        fail_en;
    logic [2:0]  fail_code;
    logic        push;
    jsu_pkg::t_job job;

    assign hex     = f_hex(i_byte);
    assign unit    = {r_code_unit[11:0], hex[3:0]};
    assign cp_pair = SUPP_BASE + {1'b0, r_high_half, unit[9:0]};

    always_comb begin
        n_phase     = r_phase;
        n_code_unit = r_code_unit;
        n_hex_seen  = r_hex_seen;
        n_high_half = r_high_half;
        fail_en     = 1'b0;
        fail_code   = jsu_pkg::E_NONE;
        push        = 1'b0;
        job         = f_single(8'h00, jsu_pkg::ST_BYTE, jsu_pkg::E_NONE);

        if (i_eoi) begin
            if (r_phase != PH_IDLE) begin
                fail_en   = 1'b1;
                fail_code = jsu_pkg::E_END;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_byte == CH_QUOTE) begin
                        n_phase = PH_BODY;
                    end else begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::E_NOQUOTE;
                    end
                end
                PH_BODY: begin
                    if (i_byte == CH_QUOTE) begin
                        n_phase     = PH_IDLE;
                        n_code_unit = '0;
                        n_hex_seen  = '0;
                        n_high_half = '0;
                        push        = 1'b1;
                        job         = f_single(8'h00, jsu_pkg::ST_CLOSE, jsu_pkg::E_NONE);
                    end else if (i_byte < CTRL_LIMIT) begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::E_CTRL;
                    end else if (i_byte == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        push = 1'b1;
                        job  = f_single(i_byte, jsu_pkg::ST_BYTE, jsu_pkg::E_NONE);
                    end
                end
                PH_ESC: begin
                    n_phase = PH_BODY;
                    push    = 1'b1;
                    case (i_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                            job = f_single(i_byte, jsu_pkg::ST_BYTE, jsu_pkg::E_NONE);
                        end
                        CH_B: job = f_single(8'h08, jsu_pkg::ST_BYTE, jsu_pkg::E_NONE);
                        CH_F: job = f_single(8'h0C, jsu_pkg::ST_BYTE, jsu_pkg::E_NONE);
                        CH_N: job = f_single(8'h0A, jsu_pkg::ST_BYTE, jsu_pkg::E_NONE);
                        CH_R: job = f_single(8'h0D, jsu_pkg::ST_BYTE, jsu_pkg::E_NONE);
                        CH_T: job = f_single(8'h09, jsu_pkg::ST_BYTE, jsu_pkg::E_NONE);
                        CH_U: begin
                            push        = 1'b0;
                            n_phase     = PH_HEX1;
                            n_code_unit = '0;
                            n_hex_seen  = '0;
                        end
                        default: begin
                            push      = 1'b0;
                            fail_en   = 1'b1;
                            fail_code = jsu_pkg::E_ESC;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2: begin
                    if (!hex[4]) begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::E_HEX;
                    end else if (r_hex_seen != 2'd3) begin
                        n_code_unit = unit;
                        n_hex_seen  = r_hex_seen + 2'd1;
                    end else begin
                        n_code_unit = '0;
                        n_hex_seen  = '0;
                        if (r_phase == PH_HEX1) begin
                            if (unit[15:10] == SURR_HIGH_TAG) begin
                                n_high_half = unit[9:0];
                                n_phase     = PH_LOWBS;
                            end else if (unit[15:10] == SURR_LOW_TAG) begin
                                fail_en   = 1'b1;
                                fail_code = jsu_pkg::E_SURR;
                            end else begin
                                n_phase = PH_BODY;
                                push    = 1'b1;
                                job     = f_utf8({5'd0, unit});
                            end
                        end else if (unit[15:10] != SURR_LOW_TAG) begin
                            fail_en   = 1'b1;
                            fail_code = jsu_pkg::E_SURR;
                        end else begin
                            n_high_half = '0;
                            n_phase     = PH_BODY;
                            push        = 1'b1;
                            job         = f_utf8(cp_pair);
                        end
                    end
                end
                PH_LOWBS: begin
                    if (i_byte != CH_BSLASH) begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::E_SURR;
                    end else begin
                        n_phase = PH_LOWU;
                    end
                end
                PH_LOWU: begin
                    if (i_byte != CH_U) begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::E_SURR;
                    end else begin
                        n_phase     = PH_HEX2;
                        n_code_unit = '0;
                        n_hex_seen  = '0;
                    end
                end
                default: begin
                    n_phase     = PH_IDLE;
                    n_code_unit = '0;
                    n_hex_seen  = '0;
                    n_high_half = '0;
                end
            endcase
        end

        // Any error drops the string and goes back to waiting for a quote.
        if (fail_en) begin
            n_phase     = PH_IDLE;
            n_code_unit = '0;
            n_hex_seen  = '0;
            n_high_half = '0;
            push        = 1'b1;
            job         = f_single(8'h00, jsu_pkg::ST_ERR, fail_code);
        end
    end

    assign o_push = i_accept && push;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_code_unit <= '0;
            r_hex_seen  <= '0;
            r_high_half <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_code_unit <= n_code_unit;
            r_hex_seen  <= n_hex_seen;
            r_high_half <= n_high_half;
        end
    end

`ifndef SYNTHESIS
    a_high_half_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_BODY) |-> (r_high_half == 10'd0))
        else $error("high surrogate held outside a pair");
`endif

endmodule

FILE: sv/jsu_queue.sv
// ============================================================================
// jsu_queue
// Short job queue between the front end and the output stage.
// ============================================================================
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_job i_job,
    input  logic          i_pop,
    output jsu_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("job queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("job queue count out of range");
`endif

endmodule

FILE: sv/jsu_back.sv
// ============================================================================
// jsu_back
// Output stage: walks the bytes of the head job, one result word per cycle
// unless stalled, into an output register reloaded as soon as it is taken.
// ============================================================================
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jsu_pkg::t_job i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic [1:0]    o_status,
    output logic [2:0]    o_error_code,
    output logic          o_last_of_run
);

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic [1:0] r_status;
    logic [2:0] r_err;
    logic       r_last;

    logic load, take, at_last;

    assign load    = !r_valid || i_ready;
    assign take    = load && !i_empty;
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = take && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_empty;
            end
            if (take) begin
                r_idx    <= at_last ? 2'd0 : r_idx + 2'd1;
                r_byte   <= i_head.bytes[r_idx];
                r_status <= i_head.status;
                r_err    <= i_head.err;
                r_last   <= at_last;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_status      = r_status;
    assign o_error_code  = r_err;
    assign o_last_of_run = r_last;

`ifndef SYNTHESIS
    a_err_code_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_status == jsu_pkg::ST_ERR) == (r_err != jsu_pkg::E_NONE)))
        else $error("error code does not match status");
    a_single_word_jobs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != jsu_pkg::ST_BYTE) |-> (r_last && r_byte == 8'h00))
        else $error("close or error word is not a lone zero word");
`endif

endmodule

FILE: sv/json_string_unescape_utf8.sv
// ============================================================================
// json_string_unescape_utf8
// JSON string unescaper: quoted string bytes in, decoded UTF-8 bytes out.
// ============================================================================
// The block takes one input word per cycle whenever the job queue has room.
// Each word is decoded in the cycle it is accepted and leaves at most one job
// in a queue of QUEUE_DEPTH entries; the output stage then sends one result
// word per cycle while i_ready is high: a plain byte or a simple escape gives
// one word, a \u escape one to four (the length of its UTF-8 sequence, a
// surrogate pair giving four). Opening quotes, backslashes and all but the
// last hex digit give no result. A word reaches its first result through the
// queue and the output register. Sustained rate is one input word per cycle
// unless the output stage falls behind on multi-byte sequences.
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic [2:0] o_error_code,
    output logic       o_last_of_run
);

    logic          accept;
    logic          push, pop, empty, full;
    jsu_pkg::t_job job, head;

    assign o_ready = !full;
    assign accept  = i_valid && !full;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .i_eoi    (i_end_of_input),
        .o_push   (push),
        .o_job    (job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

endmodule

FILE: tb/jsu_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// jsu_scoreboard_pkg
// Predicts the result words of the JSON string unescaper from the input words
// that it accepts, and checks each result word against the oldest prediction.
// ============================================================================
package jsu_scoreboard_pkg;
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE       = 21'h10000;
    localparam logic [4:0]  NOT_HEX         = 5'h10;

    typedef enum logic [3:0] {
        AWAIT_QUOTE,
        IN_BODY,
        AFTER_BACKSLASH,
        HEX_FIRST,
        WANT_BACKSLASH,
        WANT_U,
        HEX_SECOND
    } t_phase;

    typedef struct {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic [2:0] error_code;
        logic       last_of_run;
    } t_result_word;

    class unescape_scoreboard;
        t_phase       phase;
        logic [15:0]  code_unit;
        logic [1:0]   nibbles;
        logic [9:0]   high_half;
        t_result_word run[$];
        t_result_word awaited[$];
        int unsigned  failures;

        function new();
            clear_state();
            failures = 0;
        endfunction

        function void clear_state();
            phase     = AWAIT_QUOTE;
            code_unit = '0;
            nibbles   = '0;
            high_half = '0;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function logic [4:0] hex_value(logic [7:0] b);
            if (b >= "0" && b <= "9") return {1'b0, b[3:0]};
            if (b >= "a" && b <= "f") return 5'(b - 8'h57);
            if (b >= "A" && b <= "F") return 5'(b - 8'h37);
            return NOT_HEX;
        endfunction

        function void add(logic [7:0] b, logic [1:0] st, logic [2:0] err);
            t_result_word w;
            w.out_byte    = b;
            w.status      = st;
            w.error_code  = err;
            w.last_of_run = 1'b0;
            run.push_back(w);
        endfunction

        function void abort(logic [2:0] err);
            clear_state();
            add(8'h00, ST_ERR, err);
        endfunction

        function void add_code_point(logic [20:0] cp);
            if (cp < 21'h80) begin
                add(cp[7:0], ST_BYTE, E_NONE);
            end else if (cp < 21'h800) begin
                add({3'b110, cp[10:6]}, ST_BYTE, E_NONE);
                add({2'b10, cp[5:0]}, ST_BYTE, E_NONE);
            end else if (cp < SUPP_BASE) begin
                add({4'b1110, cp[15:12]}, ST_BYTE, E_NONE);
                add({2'b10, cp[11:6]}, ST_BYTE, E_NONE);
                add({2'b10, cp[5:0]}, ST_BYTE, E_NONE);
            end else begin
                add({5'b11110, cp[20:18]}, ST_BYTE, E_NONE);
                add({2'b10, cp[17:12]}, ST_BYTE, E_NONE);
                add({2'b10, cp[11:6]}, ST_BYTE, E_NONE);
                add({2'b10, cp[5:0]}, ST_BYTE, E_NONE);
            end
        endfunction

        function void decode_byte(logic [7:0] b);
            logic [4:0]  v;
            logic [15:0] unit;
            case (phase)
                AWAIT_QUOTE: begin
                    if (b == CH_QUOTE) phase = IN_BODY;
                    else abort(E_NOQUOTE);
                end
                IN_BODY: begin
                    if (b == CH_QUOTE) begin
                        clear_state();
                        add(8'h00, ST_CLOSE, E_NONE);
                    end else if (b < CH_SPACE) begin
                        abort(E_CTRL);
                    end else if (b == CH_BACKSLASH) begin
                        phase = AFTER_BACKSLASH;
                    end else begin
                        add(b, ST_BYTE, E_NONE);
                    end
                end
                AFTER_BACKSLASH: begin
                    phase = IN_BODY;
                    case (b)
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: add(b, ST_BYTE, E_NONE);
                        "b": add(8'h08, ST_BYTE, E_NONE);
                        "f": add(8'h0C, ST_BYTE, E_NONE);
                        "n": add(8'h0A, ST_BYTE, E_NONE);
                        "r": add(8'h0D, ST_BYTE, E_NONE);
                        "t": add(8'h09, ST_BYTE, E_NONE);
                        CH_U: begin
                            phase     = HEX_FIRST;
                            code_unit = '0;
                            nibbles   = '0;
                        end
                        default: abort(E_ESC);
                    endcase
                end
                HEX_FIRST, HEX_SECOND: begin
                    v = hex_value(b);
                    if (v == NOT_HEX) begin
                        abort(E_HEX);
                    end else begin
                        unit = {code_unit[11:0], v[3:0]};
                        if (nibbles < 2'd3) begin
                            code_unit = unit;
                            nibbles   = nibbles + 2'd1;
                        end else begin
                            code_unit = '0;
                            nibbles   = '0;
                            if (phase == HEX_FIRST) begin
                                if (unit >= HIGH_SURR_FIRST && unit <= HIGH_SURR_LAST) begin
                                    high_half = unit[9:0];
                                    phase     = WANT_BACKSLASH;
                                end else if (unit >= LOW_SURR_FIRST && unit <= LOW_SURR_LAST) begin
                                    abort(E_SURR);
                                end else begin
                                    phase = IN_BODY;
                                    add_code_point({5'd0, unit});
                                end
                            end else if (unit < LOW_SURR_FIRST || unit > LOW_SURR_LAST) begin
                                abort(E_SURR);
                            end else begin
                                // The high half was stored minus 0xD800, so the pair
                                // is 0x10000 plus the two ten-bit halves side by side.
                                phase = IN_BODY;
                                add_code_point(SUPP_BASE + {1'b0, high_half, unit[9:0]});
                                high_half = '0;
                            end
                        end
                    end
                end
                WANT_BACKSLASH: begin
                    if (b != CH_BACKSLASH) abort(E_SURR);
                    else phase = WANT_U;
                end
                WANT_U: begin
                    if (b != CH_U) begin
                        abort(E_SURR);
                    end else begin
                        phase     = HEX_SECOND;
                        code_unit = '0;
                        nibbles   = '0;
                    end
                end
                default: clear_state();
            endcase
        endfunction

        // Called for every input word that the block accepts.
        function void note_input(logic [7:0] b, logic eoi);
            run.delete();
            if (eoi) begin
                if (phase != AWAIT_QUOTE) abort(E_END);
            end else begin
                decode_byte(b);
            end
            if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
            foreach (run[k]) awaited.push_back(run[k]);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [7:0] b, logic [1:0] st, logic [2:0] err,
                                   logic last);
            t_result_word want;
            if (awaited.size() == 0) begin
                $display("%0t: result word with none expected: byte %h status %0d error %0d",
                         $time, b, st, err);
                failures++;
            end else begin
                want = awaited.pop_front();
                compare_field("out_byte", want.out_byte, b);
                compare_field("status", 8'(want.status), 8'(st));
                compare_field("error_code", 8'(want.error_code), 8'(err));
                compare_field("last_of_run", 8'(want.last_of_run), 8'(last));
            end
        endfunction
    endclass

endpackage

FILE: tb/tb_json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_json_string_unescape_utf8
// Feeds the unescaper directed and random quoted strings, with random idle
// cycles on the input side and random stalls on the output side, and checks
// every decoded byte, close and error word against the scoreboard.
// ============================================================================
module tb_json_string_unescape_utf8;
    import jsu_pkg::*;
    import jsu_scoreboard_pkg::*;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [7:0] i_in_byte      = 8'h00;
    logic       i_end_of_input = 1'b0;
    logic       i_ready        = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic [1:0] o_status;
    logic [2:0] o_error_code;
    logic       o_last_of_run;

    // Bit 8 marks an end-of-input word.
    logic [8:0] stream[$];
    bit         calm = 1'b0;
    unescape_scoreboard sb;

    json_string_unescape_utf8 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 23);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_out_byte, o_status, o_error_code, o_last_of_run);
        end
    end

    function automatic void push_byte(logic [7:0] b);
        stream.push_back({1'b0, b});
    endfunction

    // The byte lane carries noise on an end word; the block must ignore it.
    function automatic void push_end();
        stream.push_back({1'b1, 8'($urandom)});
    endfunction

    function automatic void push_text(string s);
        for (int k = 0; k < s.len(); k++) push_byte(s[k]);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'("0") + 8'(nib);
        return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(nib) - 8'd10;
    endfunction

    function automatic void push_hex(logic [15:0] unit);
        push_byte(CH_BACKSLASH);
        push_byte(CH_U);
        for (int k = 3; k >= 0; k--) push_byte(hex_char(unit[4*k +: 4]));
    endfunction

    function automatic logic [15:0] random_high();
        return HIGH_SURR_FIRST + 16'($urandom_range(0, 16'h3FF));
    endfunction

    function automatic logic [7:0] random_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(CH_SPACE, 8'hFF));
        while (b == CH_QUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    function automatic void push_element();
        string       letters;
        int unsigned pick;
        logic [15:0] cp;
        letters = "\"\\/bfnrt";
        pick = $urandom_range(99);
        if (pick < 40) begin
            push_byte(random_plain());
        end else if (pick < 65) begin
            push_byte(CH_BACKSLASH);
            push_byte(letters[$urandom_range(0, 7)]);
        end else if (pick < 85) begin
            // Spread code points over the one, two and three byte forms.
            case ($urandom_range(0, 2))
                0: cp = 16'($urandom_range(0, 16'h7F));
                1: cp = 16'($urandom_range(16'h80, 16'h7FF));
                default: begin
                    do cp = 16'($urandom_range(16'h800, 16'hFFFF));
                    while (cp >= HIGH_SURR_FIRST && cp <= LOW_SURR_LAST);
                end
            endcase
            push_hex(cp);
        end else begin
            push_hex(random_high());
            push_hex(LOW_SURR_FIRST + 16'($urandom_range(0, 16'h3FF)));
        end
    endfunction

    function automatic void push_fault();
        logic [7:0]  b;
        logic [15:0] unit;
        case ($urandom_range(0, 8))
            0: push_byte(8'($urandom_range(0, CH_SPACE - 1)));
            1: begin
                push_byte(CH_BACKSLASH);
                push_byte(8'($urandom));
            end
            2: begin
                push_byte(CH_BACKSLASH);
                push_byte(CH_U);
                repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom)));
                do b = 8'($urandom);
                while (sb.hex_value(b) != NOT_HEX);
                push_byte(b);
            end
            3: push_hex(LOW_SURR_FIRST + 16'($urandom_range(0, 16'h3FF)));
            4: begin
                push_hex(random_high());
                push_byte(random_plain());
            end
            5: begin
                push_hex(random_high());
                push_byte(CH_BACKSLASH);
                do b = 8'($urandom);
                while (b == CH_U);
                push_byte(b);
            end
            6: begin
                push_hex(random_high());
                do unit = 16'($urandom);
                while (unit >= LOW_SURR_FIRST && unit <= LOW_SURR_LAST);
                push_hex(unit);
            end
            7: begin
                // Input runs out inside an escape or a hex group.
                push_byte(CH_BACKSLASH);
                if ($urandom_range(1)) begin
                    push_byte(CH_U);
                    repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom)));
                end
                push_end();
            end
            default: push_end();
        endcase
    endfunction

    // A quoted string; a broken one carries one fault and is followed by an
    // end word so that the block is back at the opening quote afterwards.
    function automatic void push_string();
        int unsigned n;
        int unsigned at;
        bit          broken;
        n      = $urandom_range(0, 8);
        at     = $urandom_range(0, n);
        broken = ($urandom_range(99) < 20);
        push_byte(CH_QUOTE);
        for (int unsigned k = 0; k <= n; k++) begin
            if (broken && k == at) push_fault();
            if (k < n) push_element();
        end
        push_byte(CH_QUOTE);
        if (broken || $urandom_range(99) < 5) push_end();
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(logic [7:0] b, logic eoi);
        while (!calm && $urandom_range(99) < 23) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_in_byte      <= b;
        i_end_of_input <= eoi;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(b, eoi);
        @(negedge i_clk);
    endtask

    initial begin
        sb = new();

        push_end();
        push_byte(8'h00);
        push_byte(CH_QUOTE);
        push_byte(CH_SPACE);
        push_byte(8'hFF);
        push_byte(8'h1F);
        push_text("\"\\q");
        push_text("\"\\udbff\\uDFFF\"");
        push_text("\"\\");
        push_end();

        while (stream.size() < 320) begin
            if ($urandom_range(99) < 10) begin
                push_byte(8'($urandom));
                push_end();
            end else begin
                push_string();
            end
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stream[k]) begin
            calm = (k >= 120 && k < 200);
            send_word(stream[k][7:0], stream[k][8]);
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d result words outstanding", $time, sb.pending());
        $display("FAIL");
        $finish;
    end

endmodule
